// ----- design/assert_macros.svh -----
// Assertion macros shared by the stable max priority queue RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SMPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SMPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

// Invariant that holds at every clock edge out of reset.
`define SMPQ_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("smpq assertion failed");

`endif

// ----- design/smpq_pkg.sv -----
// Shared types for the stable max priority queue.
// No dependencies; used by the cell, the read tree and the top level.
package smpq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_CHECK = 2'd3
    } smpq_cmd_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } smpq_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } smpq_state_t;

endpackage

// ----- design/stable_max_priority_queue.sv -----
// Stable max priority queue: a chain of CAPACITY cells keeps the entries sorted,
// best at cell 0, equal scores in arrival order. Every request yields exactly one
// result. Push, pop and init_check requests are taken back to back while the
// result side keeps up: a push compares its score in every cell at once and each
// cell takes the new entry, its left neighbor's entry or keeps its own; a pop
// shifts every cell one step toward the front. For a check_next request the entry
// under the read cursor travels up a registered OR tree, one level per cycle, while
// the sequencer waits in ST_WALK and then in ST_DONE for the result register, and
// no new request is taken until it has been returned. A push to a full queue is
// dropped and reported through m_overflow. There is no clearing pass after reset;
// only occupied cells are ever read.
module stable_max_priority_queue #(
    parameter int CAPACITY      = 64,
    parameter int SCORE_WIDTH   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic signed [SCORE_WIDTH-1:0]   s_score,
    input  logic [PAYLOAD_WIDTH-1:0]        s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic signed [SCORE_WIDTH-1:0]   m_out_score,
    output logic [PAYLOAD_WIDTH-1:0]        m_out_payload,
    output logic                            m_overflow
);
    import smpq_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DATA_W = SCORE_WIDTH + PAYLOAD_WIDTH;

    // ------------------------------------------------------------------
    // Handshake and command decode
    // ------------------------------------------------------------------
    smpq_state_t       state_reg, state_next;
    logic [WAIT_W-1:0] wait_reg,  wait_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;

    logic                            m_valid_reg,   m_valid_next;
    logic                            found_reg,     found_next;
    logic signed [SCORE_WIDTH-1:0]   score_reg,     score_next;
    logic [PAYLOAD_WIDTH-1:0]        payload_reg,   payload_next;
    logic                            overflow_reg,  overflow_next;

    smpq_cmd_t cmd;
    smpq_ctl_t ctl;
    logic      s_accept;
    logic      out_free;
    logic      full;
    logic      empty;
    logic      bump;
    logic      chk_found;
    logic      push_drop;

    assign cmd      = smpq_cmd_t'(s_cmd);
    assign out_free = !m_valid_reg || m_ready;
    // Take a request only when idle and the result register can take its answer.
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_valid && s_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Drop pushes to a full queue and pops from an empty one at the cells.
    assign ctl.push = s_accept && (cmd == CMD_PUSH) && !full;
    assign ctl.pop  = s_accept && (cmd == CMD_POP) && !empty;

    // A push accepted while full is dropped and flagged.
    assign push_drop = s_accept && (cmd == CMD_PUSH) && full;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    logic signed [SCORE_WIDTH-1:0]   cell_score   [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0]        cell_payload [CAPACITY];
    logic [CAPACITY-1:0]             cell_keep;
    logic [CAPACITY-1:0]             cell_occ;
    logic [CAPACITY-1:0]             ahead_of_cursor;
    logic [CAPACITY-1:0][DATA_W-1:0] leaf_data;
    logic [DATA_W-1:0]               tree_root;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic                            left_keep;
            logic signed [SCORE_WIDTH-1:0]   left_score;
            logic [PAYLOAD_WIDTH-1:0]        left_payload;
            logic signed [SCORE_WIDTH-1:0]   right_score;
            logic [PAYLOAD_WIDTH-1:0]        right_payload;

            assign cell_occ[i] = (CNT_W'(i) < count_reg);

            // The front cell has nothing to its left: an insert there takes the new entry.
            if (i == 0) begin : g_front
                assign left_keep    = 1'b1;
                assign left_score   = s_score;
                assign left_payload = s_payload;
            end else begin : g_mid
                assign left_keep    = cell_keep[i-1];
                assign left_score   = cell_score[i-1];
                assign left_payload = cell_payload[i-1];
            end

            // The last cell holds its own entry on a pop; it falls out of the count anyway.
            if (i == CAPACITY - 1) begin : g_back
                assign right_score   = cell_score[i];
                assign right_payload = cell_payload[i];
            end else begin : g_inner
                assign right_score   = cell_score[i+1];
                assign right_payload = cell_payload[i+1];
            end

            smpq_cell #(
                .SCORE_WIDTH   (SCORE_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .aclk          (aclk),
                .ctl           (ctl),
                .occupied      (cell_occ[i]),
                .left_keep     (left_keep),
                .new_score     (s_score),
                .new_payload   (s_payload),
                .left_score    (left_score),
                .left_payload  (left_payload),
                .right_score   (right_score),
                .right_payload (right_payload),
                .keep          (cell_keep[i]),
                .score         (cell_score[i]),
                .payload       (cell_payload[i])
            );

            // A push lands ahead of the cursor when some cell in front of it moves.
            assign ahead_of_cursor[i] = (CNT_W'(i) < cursor_reg) && !cell_keep[i];

            // Only the occupied cell under the cursor feeds the read tree.
            assign leaf_data[i] = ((CNT_W'(i) == cursor_reg) && cell_occ[i]) ?
                                  {cell_score[i], cell_payload[i]} : '0;
        end
    endgenerate

    assign bump      = |ahead_of_cursor;
    assign chk_found = (cursor_reg < count_reg);

    smpq_sel_tree #(
        .N_LEAVES (CAPACITY),
        .DATA_W   (DATA_W)
    ) u_sel_tree (
        .aclk      (aclk),
        .leaf_data (leaf_data),
        .root      (tree_root)
    );

    // ------------------------------------------------------------------
    // Sequencer, counters and result register
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        found_next    = found_reg;
        score_next    = score_reg;
        payload_next  = payload_reg;
        overflow_next = overflow_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (cmd)
                        CMD_PUSH: begin
                            m_valid_next  = 1'b1;
                            found_next    = 1'b0;
                            score_next    = '0;
                            payload_next  = '0;
                            overflow_next = full;
                            if (!full) begin
                                count_next = count_reg + CNT_W'(1);
                                // Keep the cursor on the same entry.
                                if (bump) begin
                                    cursor_next = cursor_reg + CNT_W'(1);
                                end
                            end
                        end
                        CMD_POP: begin
                            m_valid_next  = 1'b1;
                            overflow_next = 1'b0;
                            if (empty) begin
                                found_next   = 1'b0;
                                score_next   = '0;
                                payload_next = '0;
                            end else begin
                                found_next   = 1'b1;
                                score_next   = cell_score[0];
                                payload_next = cell_payload[0];
                                count_next   = count_reg - CNT_W'(1);
                                if (cursor_reg != '0) begin
                                    cursor_next = cursor_reg - CNT_W'(1);
                                end
                            end
                        end
                        CMD_INIT: begin
                            m_valid_next  = 1'b1;
                            found_next    = 1'b0;
                            score_next    = '0;
                            payload_next  = '0;
                            overflow_next = 1'b0;
                            cursor_next   = '0;
                        end
                        CMD_CHECK: begin
                            // Hold everything while the selected entry climbs the tree.
                            state_next = ST_WALK;
                            wait_next  = WAIT_W'(LEVELS - 1);
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (wait_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_valid_next  = 1'b1;
                    found_next    = chk_found;
                    overflow_next = 1'b0;
                    if (chk_found) begin
                        score_next   = tree_root[DATA_W-1 -: SCORE_WIDTH];
                        payload_next = tree_root[PAYLOAD_WIDTH-1:0];
                        cursor_next  = cursor_reg + CNT_W'(1);
                    end else begin
                        score_next   = '0;
                        payload_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg    <= found_next;
        score_reg    <= score_next;
        payload_reg  <= payload_next;
        overflow_reg <= overflow_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_out_score   = score_reg;
    assign m_out_payload = payload_reg;
    assign m_overflow    = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SMPQ_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `SMPQ_ASSERT_ALWAYS(a_cursor_bound, aclk, aresetn, cursor_reg <= count_reg)
    `SMPQ_ASSERT_NEXT(a_full_push_drop, aclk, aresetn, push_drop, $stable(count_reg) && m_overflow)
    `SMPQ_ASSERT_IMPL(a_busy_no_accept, aclk, aresetn, state_reg != ST_IDLE, !s_ready)

endmodule

// ----- design/smpq_cell.sv -----
// One slot of the sorted chain: holds a score and payload, shifts to its neighbors.
// Depends on smpq_pkg.
module smpq_cell #(
    parameter int SCORE_WIDTH   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                            aclk,
    input  smpq_pkg::smpq_ctl_t             ctl,
    input  logic                            occupied,
    input  logic                            left_keep,
    input  logic signed [SCORE_WIDTH-1:0]   new_score,
    input  logic        [PAYLOAD_WIDTH-1:0] new_payload,
    input  logic signed [SCORE_WIDTH-1:0]   left_score,
    input  logic        [PAYLOAD_WIDTH-1:0] left_payload,
    input  logic signed [SCORE_WIDTH-1:0]   right_score,
    input  logic        [PAYLOAD_WIDTH-1:0] right_payload,
    output logic                            keep,
    output logic signed [SCORE_WIDTH-1:0]   score,
    output logic        [PAYLOAD_WIDTH-1:0] payload
);
    import smpq_pkg::*;

    logic signed [SCORE_WIDTH-1:0]   score_reg,   score_next;
    logic        [PAYLOAD_WIDTH-1:0] payload_reg, payload_next;

    // Entry stays in place on a push when it ranks at or above the new one.
    assign keep = occupied && (score_reg >= new_score);

    always_comb begin
        score_next   = score_reg;
        payload_next = payload_reg;
        if (ctl.push && !keep) begin
            if (left_keep) begin
                score_next   = new_score;
                payload_next = new_payload;
            end else begin
                score_next   = left_score;
                payload_next = left_payload;
            end
        end else if (ctl.pop) begin
            score_next   = right_score;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge aclk) begin
        score_reg   <= score_next;
        payload_reg <= payload_next;
    end

    assign score   = score_reg;
    assign payload = payload_reg;

endmodule

// ----- design/smpq_sel_tree.sv -----
// Registered OR tree that gathers the one selected cell onto a single bus.
// Depends on smpq_pkg (for house consistency); leaves are zero except the chosen one.
module smpq_sel_tree #(
    parameter int N_LEAVES = 64,
    parameter int DATA_W   = 48
) (
    input  logic                             aclk,
    input  logic [N_LEAVES-1:0][DATA_W-1:0]  leaf_data,
    output logic [DATA_W-1:0]                root
);
    import smpq_pkg::*;

    localparam int LEVELS = (N_LEAVES > 1) ? $clog2(N_LEAVES) : 1;
    localparam int P2     = 1 << LEVELS;

    // Heap order: node 1 is the root, nodes P2 .. 2*P2-1 are the leaves.
    logic [DATA_W-1:0] node_val [1:2*P2-1];
    logic [DATA_W-1:0] node_reg [1:P2-1];

    genvar k;
    generate
        for (k = 0; k < P2; k++) begin : g_leaf
            if (k < N_LEAVES) begin : g_used
                assign node_val[P2+k] = leaf_data[k];
            end else begin : g_pad
                assign node_val[P2+k] = '0;
            end
        end
        for (k = 1; k < P2; k++) begin : g_node
            always_ff @(posedge aclk) begin
                node_reg[k] <= node_val[2*k] | node_val[2*k+1];
            end
            assign node_val[k] = node_reg[k];
        end
    endgenerate

    assign root = node_val[1];

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the stable max priority queue (smpq_pkg, top level).
// Runs directed and random request streams through a local predictor of the queue
// and checks every result against it.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int SCORE_WIDTH   = 16;
    localparam int PAYLOAD_WIDTH = 32;

    // Generous ceiling: several times the slowest legal run, which is bounded by
    // check_next requests behind a receiver stalling most cycles.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles to wait for outstanding results once stimulus is done.
    localparam int DRAIN_LIMIT   = 5000;
    // Quiet cycles after the last result: covers the check_next read tree.
    localparam int TAIL_CYCLES   = 24;

    typedef struct {
        logic signed [SCORE_WIDTH-1:0] score;
        logic [PAYLOAD_WIDTH-1:0]      payload;
    } entry_t;

    typedef struct {
        logic                          found;
        logic signed [SCORE_WIDTH-1:0] score;
        logic [PAYLOAD_WIDTH-1:0]      payload;
        logic                          overflow;
    } result_t;

    // DUT ports; every input starts at a known value.
    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_cmd = CMD_PUSH;
    logic signed [SCORE_WIDTH-1:0]   s_score = '0;
    logic [PAYLOAD_WIDTH-1:0]        s_payload = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_found;
    logic signed [SCORE_WIDTH-1:0]   m_out_score;
    logic [PAYLOAD_WIDTH-1:0]        m_out_payload;
    logic                            m_overflow;

    // Predictor state: entries in output order (front is best) and the read cursor.
    entry_t  queued_entries[$];
    int      model_cursor = 0;

    // Results the block owes, oldest first.
    result_t expected_results[$];

    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      cycle_count    = 0;

    // Idling knobs, percent of cycles.
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    // Long receiver hold-off: request set by a test, counted down by the receiver.
    int      hold_request   = 0;
    int      hold_left      = 0;

    stable_max_priority_queue #(
        .CAPACITY      (CAPACITY),
        .SCORE_WIDTH   (SCORE_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_score       (s_score),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_out_score   (m_out_score),
        .m_out_payload (m_out_payload),
        .m_overflow    (m_overflow)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Apply one request to the predictor and return what the block must answer.
    function automatic result_t predict_result(smpq_cmd_t cmd,
                                               logic signed [SCORE_WIDTH-1:0] score,
                                               logic [PAYLOAD_WIDTH-1:0] payload);
        result_t r;
        entry_t  e;
        int      pos;
        r.found    = 1'b0;
        r.score    = '0;
        r.payload  = '0;
        r.overflow = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (queued_entries.size() >= CAPACITY) begin
                    // Full: drop the entry, flag it, leave everything else alone.
                    r.overflow = 1'b1;
                end else begin
                    // Land behind every entry scoring greater or equal (FIFO on ties).
                    pos = 0;
                    while (pos < queued_entries.size() && queued_entries[pos].score >= score)
                        pos++;
                    e.score   = score;
                    e.payload = payload;
                    queued_entries.insert(pos, e);
                    // Keep the cursor on the same entry when the new one lands ahead.
                    if (pos < model_cursor)
                        model_cursor++;
                end
            end
            CMD_POP: begin
                if (queued_entries.size() != 0) begin
                    e = queued_entries.pop_front();
                    r.found   = 1'b1;
                    r.score   = e.score;
                    r.payload = e.payload;
                    if (model_cursor > 0)
                        model_cursor--;
                end
            end
            CMD_INIT: begin
                model_cursor = 0;
            end
            CMD_CHECK: begin
                // Past the end the cursor stays put and no entry is found.
                if (model_cursor < queued_entries.size()) begin
                    r.found   = 1'b1;
                    r.score   = queued_entries[model_cursor].score;
                    r.payload = queued_entries[model_cursor].payload;
                    model_cursor++;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("mismatch at result %0d (cycle %0d): %s", results_seen, cycle_count, what);
    endtask

    task automatic compare_result();
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request pending");
            return;
        end
        want = expected_results.pop_front();
        if (m_found !== want.found)
            report_mismatch($sformatf("found %b, want %b", m_found, want.found));
        if (m_out_score !== want.score)
            report_mismatch($sformatf("out_score %0d, want %0d", m_out_score, want.score));
        if (m_out_payload !== want.payload)
            report_mismatch($sformatf("out_payload %h, want %h", m_out_payload, want.payload));
        if (m_overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, want %b", m_overflow, want.overflow));
    endtask

    // Watch both handshakes at each edge: predict accepted requests first, then
    // check the accepted result, so a same-edge answer still finds its expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(smpq_cmd_t'(s_cmd), s_score,
                                                          s_payload));
            if (m_valid && m_ready) begin
                compare_result();
                results_seen++;
            end
        end
    end

    // Receiver: stall at random, or hold off for a whole stretch when a test asks.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request and hold it until the block takes it. Valid is only lowered
    // in idle gaps, so back-to-back requests never see a low/high pair in one step.
    task automatic send_request(smpq_cmd_t cmd, logic [SCORE_WIDTH-1:0] score,
                                logic [PAYLOAD_WIDTH-1:0] payload);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_score   <= score;
        s_payload <= payload;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Mostly a handful of nearby scores so ties are common, sometimes anything.
    function automatic logic [SCORE_WIDTH-1:0] random_score();
        if ($urandom_range(3) == 0)
            return SCORE_WIDTH'($urandom);
        return SCORE_WIDTH'(int'($urandom_range(8)) - 4);
    endfunction

    // One random request; weights are percentages for push, pop and init_check,
    // the rest goes to check_next.
    task automatic send_random_request(int push_w, int pop_w, int init_w);
        int        pick;
        smpq_cmd_t cmd;
        pick = $urandom_range(99);
        if (pick < push_w)
            cmd = CMD_PUSH;
        else if (pick < push_w + pop_w)
            cmd = CMD_POP;
        else if (pick < push_w + pop_w + init_w)
            cmd = CMD_INIT;
        else
            cmd = CMD_CHECK;
        send_request(cmd, random_score(), $urandom);
    endtask

    // Pop, check_next and init_check on an empty queue all answer with zeros.
    task automatic test_empty_queue();
        send_request(CMD_POP,   16'h1234, 32'h1);
        send_request(CMD_CHECK, 16'h8000, 32'hffff_ffff);
        send_request(CMD_INIT,  16'h7fff, 32'h0);
        send_request(CMD_CHECK, 16'h0,    32'h0);
    endtask

    // Score extremes, ties kept in arrival order, then drain past empty.
    task automatic test_order_and_ties();
        send_request(CMD_PUSH, 16'd5,    32'ha1a1_a1a1);
        send_request(CMD_PUSH, 16'd5,    32'ha2a2_a2a2);
        send_request(CMD_PUSH, 16'h7fff, 32'hffff_ffff);
        send_request(CMD_PUSH, 16'h8000, 32'h0000_0000);
        send_request(CMD_PUSH, 16'hffff, 32'h1234_5678);
        repeat (6)
            send_request(CMD_POP, 16'h0, 32'h0);
    endtask

    // Walk the cursor while pushes land ahead of and behind it, and pops move it.
    task automatic test_check_cursor();
        send_request(CMD_PUSH,  16'd10,   32'h0000_0001);
        send_request(CMD_PUSH,  16'd0,    32'h0000_0002);
        send_request(CMD_INIT,  16'h0,    32'h0);
        send_request(CMD_CHECK, 16'h0,    32'h0);
        send_request(CMD_PUSH,  16'd20,   32'h0000_0003);
        send_request(CMD_PUSH,  16'd0,    32'h0000_0004);
        send_request(CMD_CHECK, 16'h0,    32'h0);
        send_request(CMD_CHECK, 16'h0,    32'h0);
        send_request(CMD_CHECK, 16'h0,    32'h0);
        send_request(CMD_POP,   16'h0,    32'h0);
        send_request(CMD_CHECK, 16'h0,    32'h0);
        send_request(CMD_INIT,  16'h0,    32'h0);
        send_request(CMD_POP,   16'h0,    32'h0);
        send_request(CMD_CHECK, 16'h0,    32'h0);
    endtask

    // Hold the receiver off while pushing past capacity: the block backs up and
    // stalls its input, the extra pushes overflow; then send a pop-heavy random run.
    task automatic test_full_queue_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 400;
        repeat (CAPACITY + 6)
            send_request(CMD_PUSH, random_score(), $urandom);
        send_request(CMD_INIT, 16'h0, 32'h0);
        repeat (8)
            send_request(CMD_CHECK, 16'h0, 32'h0);
        repeat (CAPACITY + 3)
            send_random_request(0, 90, 2);
    endtask

    // Random traffic under each idling pattern; push-heavy and pop-heavy phases
    // alternate so the queue swings between empty and full.
    task automatic test_random_traffic();
        send_idle_pct = 0;  recv_stall_pct = 0;
        repeat (130) send_random_request(55, 20, 5);
        send_idle_pct = 67; recv_stall_pct = 0;
        repeat (130) send_random_request(25, 45, 10);
        send_idle_pct = 0;  recv_stall_pct = 67;
        repeat (130) send_random_request(60, 15, 5);
        send_idle_pct = 8;  recv_stall_pct = 8;
        repeat (130) send_random_request(30, 40, 10);
    endtask

    initial begin
        int waited;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_order_and_ties();
        test_check_cursor();
        test_full_queue_backpressure();
        test_random_traffic();

        // Stop offering, let the receiver run freely, and collect what is owed.
        s_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- stable_max_priority_queue.f -----
+incdir+design
design/smpq_pkg.sv
design/smpq_cell.sv
design/smpq_sel_tree.sv
design/stable_max_priority_queue.sv
tb/tb_top.sv
